FILE: src/host_availability_tracker_core_defines.svh
// Assertion macros for the host availability tracker.
// Used by the port checker; expects clk and rst_n in the enclosing scope.
`ifndef HOST_AVAILABILITY_TRACKER_CORE_DEFINES_SVH
`define HOST_AVAILABILITY_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/hat_pkg.sv
// Shared types and constants for the host availability tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package hat_pkg;

    // Field and storage widths
    localparam int PCNT_W    = 32;
    localparam int TIME_W    = 24;
    localparam int EVT_W     = 16;
    localparam int THR_W     = 8;
    localparam int AVL_W     = 14;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = PCNT_W + AVL_W;
    localparam int QUO_W     = TIME_W;
    localparam int STEP_W    = $clog2(QUO_W + 1);

    // Availability scale: hundredths of a percent
    localparam logic [AVL_W-1:0] AVL_SCALE = AVL_W'(10000);

    // Saturation limits
    localparam logic [PCNT_W-1:0] PCNT_MAX = '1;
    localparam logic [EVT_W-1:0]  EVT_MAX  = '1;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REC_THR  = CFG_IDX_W'(1);
    localparam logic [THR_W-1:0]     FAIL_THR_RST = THR_W'(2);
    localparam logic [THR_W-1:0]     REC_THR_RST  = THR_W'(3);

    typedef enum logic [1:0] {
        HS_UNKNOWN    = 2'd0,
        HS_UP         = 2'd1,
        HS_DOWN       = 2'd2,
        HS_RECOVERING = 2'd3
    } host_state_t;

    typedef enum logic [1:0] {
        METH_NONE = 2'd0,
        METH_SNMP = 2'd1,
        METH_PING = 2'd2,
        METH_BOTH = 2'd3
    } method_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic prep;
        logic mean_fin;
        logic avl_start;
        logic load_out;
    } hat_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic was_up;
        logic div_busy;
    } hat_sts_t;

endpackage

`default_nettype wire

FILE: src/hat_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on hat_pkg.
`default_nettype none

module hat_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [hat_pkg::PCNT_W-1:0] init_rem,
    input  logic [hat_pkg::QUO_W-1:0]  init_quo,
    input  logic [hat_pkg::PCNT_W-1:0] divisor,
    input  logic [hat_pkg::STEP_W-1:0] steps,
    output logic                       busy,
    output logic [hat_pkg::QUO_W-1:0]  quotient,
    output logic                       rem_nz
);
    import hat_pkg::*;

    logic [PCNT_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [PCNT_W-1:0] dvs_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [PCNT_W:0]   shifted;
    logic [PCNT_W:0]   diff;
    logic              take;

    // One trial subtraction per step; remainder stays below the divisor
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign take    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = init_rem;
            quo_next = init_quo;
            cnt_next = steps;
        end
        else if (busy)
        begin
            rem_next = take ? diff[PCNT_W-1:0] : shifted[PCNT_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], take};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

`default_nettype wire

FILE: src/hat_dp.sv
// Datapath: config registers, host state, poll counters, time statistics,
// mean and availability division, output register. Depends on hat_pkg, hat_div.
`default_nettype none

module hat_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hat_pkg::hat_cmd_t             cmd,
    output hat_pkg::hat_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [hat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hat_pkg::THR_W-1:0]     cfg_data,
    input  logic                          poll_up,
    input  logic [1:0]                    method,
    input  logic                          community_set,
    input  logic [hat_pkg::TIME_W-1:0]    ping_rtt,
    input  logic [hat_pkg::TIME_W-1:0]    snmp_time,
    output logic [1:0]                    host_state,
    output logic [hat_pkg::EVT_W-1:0]     event_count,
    output logic                          state_event,
    output logic                          mark_fail_date,
    output logic                          mark_recover_date,
    output logic [hat_pkg::PCNT_W-1:0]    total_count,
    output logic [hat_pkg::PCNT_W-1:0]    failed_count,
    output logic [hat_pkg::AVL_W-1:0]     availability,
    output logic [hat_pkg::TIME_W-1:0]    current_time,
    output logic [hat_pkg::TIME_W-1:0]    minimum_time,
    output logic [hat_pkg::TIME_W-1:0]    maximum_time,
    output logic [hat_pkg::TIME_W-1:0]    average_time
);
    import hat_pkg::*;

    // Configuration
    logic [THR_W-1:0]  thr_fail_reg, thr_rec_reg;

    // Tracker state
    host_state_t       st_reg, st_next;
    logic [EVT_W-1:0]  evt_reg, evt_next;
    logic [PCNT_W-1:0] total_reg, total_next;
    logic [PCNT_W-1:0] failed_reg, failed_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] min_reg, min_next;
    logic [TIME_W-1:0] max_reg, max_next;
    logic [TIME_W-1:0] mean_reg;
    logic              ev_reg, ev_next;
    logic              fd_reg, fd_next;
    logic              rd_reg, rd_next;
    logic              up_reg;

    // Division bookkeeping
    logic [PCNT_W-1:0] upc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              rise_reg;

    logic [EVT_W-1:0]  evt_bump;
    logic [EVT_W-1:0]  rec_cnt;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] ptime;
    logic [PCNT_W-1:0] upc;
    logic [PCNT_W-1:0] mean_div;
    logic [TIME_W-1:0] mean_gap;

    logic              div_start;
    logic [PCNT_W-1:0] div_rem;
    logic [QUO_W-1:0]  div_quo;
    logic [PCNT_W-1:0] div_dvs;
    logic [STEP_W-1:0] div_steps;
    logic              div_busy;
    logic [QUO_W-1:0]  div_q;
    logic              div_rnz;

    // Poll time selection
    assign time_sum = {1'b0, snmp_time} + {1'b0, ping_rtt};

    always_comb
    begin
        case (method_t'(method))
            METH_BOTH: ptime = community_set ? time_sum[TIME_W:1] : ping_rtt;
            METH_SNMP: ptime = community_set ? snmp_time : '0;
            METH_PING: ptime = ping_rtt;
            METH_NONE: ptime = '0;
            default:   ptime = '0;
        endcase
    end

    // Saturating event counter step
    assign evt_bump = (evt_reg == EVT_MAX) ? evt_reg : evt_reg + 1'b1;
    assign rec_cnt  = (st_reg == HS_DOWN) ? EVT_W'(1) : evt_bump;

    // Next tracker state for an accepted poll
    always_comb
    begin
        st_next     = st_reg;
        evt_next    = evt_reg;
        ev_next     = 1'b0;
        fd_next     = 1'b0;
        rd_next     = 1'b0;
        total_next  = (total_reg == PCNT_MAX) ? total_reg : total_reg + 1'b1;
        failed_next = failed_reg;
        now_next    = now_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        if (!poll_up)
        begin
            failed_next = (failed_reg == PCNT_MAX) ? failed_reg : failed_reg + 1'b1;
            case (st_reg)
                HS_UP:
                begin
                    evt_next = evt_bump;
                    if (evt_bump >= EVT_W'(thr_fail_reg))
                    begin
                        st_next = HS_DOWN;
                        ev_next = 1'b1;
                        fd_next = (thr_fail_reg == THR_W'(1));
                    end
                    else
                    begin
                        fd_next = (evt_bump == EVT_W'(1));
                    end
                end
                HS_RECOVERING:
                begin
                    evt_next = EVT_W'(1);
                    st_next  = HS_DOWN;
                end
                HS_UNKNOWN:
                begin
                    evt_next = '0;
                    st_next  = HS_DOWN;
                end
                default:
                begin
                    evt_next = evt_bump;
                end
            endcase
        end
        else
        begin
            now_next = ptime;
            min_next = (ptime < min_reg) ? ptime : min_reg;
            max_next = (ptime > max_reg) ? ptime : max_reg;
            case (st_reg)
                HS_DOWN, HS_RECOVERING:
                begin
                    st_next  = HS_RECOVERING;
                    evt_next = rec_cnt;
                    if (rec_cnt >= EVT_W'(thr_rec_reg))
                    begin
                        st_next  = HS_UP;
                        ev_next  = 1'b1;
                        rd_next  = (thr_rec_reg == THR_W'(1));
                        evt_next = '0;
                    end
                    else
                    begin
                        rd_next = (rec_cnt == EVT_W'(1));
                    end
                end
                default:
                begin
                    st_next  = HS_UP;
                    evt_next = '0;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_fail_reg <= FAIL_THR_RST;
            thr_rec_reg  <= REC_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAIL_THR: thr_fail_reg <= cfg_data;
                CFG_REC_THR:  thr_rec_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Up-poll count and mean operands
    assign upc      = total_reg - failed_reg;
    assign mean_div = (upc == '0) ? PCNT_W'(1) : upc;
    assign mean_gap = (now_reg >= mean_reg) ? now_reg - mean_reg : mean_reg - now_reg;

    // Tracker state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= HS_UNKNOWN;
            evt_reg    <= '0;
            total_reg  <= '0;
            failed_reg <= '0;
            now_reg    <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            mean_reg   <= '0;
            ev_reg     <= 1'b0;
            fd_reg     <= 1'b0;
            rd_reg     <= 1'b0;
            up_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                st_reg     <= st_next;
                evt_reg    <= evt_next;
                total_reg  <= total_next;
                failed_reg <= failed_next;
                now_reg    <= now_next;
                min_reg    <= min_next;
                max_reg    <= max_next;
                ev_reg     <= ev_next;
                fd_reg     <= fd_next;
                rd_reg     <= rd_next;
                up_reg     <= poll_up;
            end
            // rising mean adds the floor, falling mean subtracts the ceiling
            if (cmd.mean_fin)
            begin
                if (rise_reg)
                begin
                    mean_reg <= mean_reg + div_q[TIME_W-1:0];
                end
                else
                begin
                    mean_reg <= mean_reg - div_q[TIME_W-1:0]
                                - {{(TIME_W-1){1'b0}}, div_rnz};
                end
            end
        end
    end

    // Division operand staging
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            upc_reg  <= upc;
            rise_reg <= (now_reg >= mean_reg);
        end
        prod_reg <= PROD_W'(upc_reg) * PROD_W'(AVL_SCALE);
    end

    // Divider setup: mean step or availability
    assign div_start = (cmd.prep && up_reg) || cmd.avl_start;
    assign div_rem   = cmd.avl_start ? prod_reg[PROD_W-1:AVL_W] : '0;
    assign div_quo   = cmd.avl_start ?
                       {prod_reg[AVL_W-1:0], {(QUO_W-AVL_W){1'b0}}} : mean_gap;
    assign div_dvs   = cmd.avl_start ? total_reg : mean_div;
    assign div_steps = cmd.avl_start ? STEP_W'(AVL_W) : STEP_W'(QUO_W);

    hat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .init_rem (div_rem),
        .init_quo (div_quo),
        .divisor  (div_dvs),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_q),
        .rem_nz   (div_rnz)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            host_state        <= st_reg;
            event_count       <= evt_reg;
            state_event       <= ev_reg;
            mark_fail_date    <= fd_reg;
            mark_recover_date <= rd_reg;
            total_count       <= total_reg;
            failed_count      <= failed_reg;
            availability      <= div_q[AVL_W-1:0];
            current_time      <= now_reg;
            minimum_time      <= min_reg;
            maximum_time      <= max_reg;
            average_time      <= mean_reg;
        end
    end

    assign sts.was_up   = up_reg;
    assign sts.div_busy = div_busy;

endmodule

`default_nettype wire

FILE: src/hat_ctrl.sv
// Controller: sequences capture, mean division, availability division and
// the output handshake. Depends on hat_pkg.
`default_nettype none

module hat_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hat_pkg::hat_cmd_t cmd,
    input  hat_pkg::hat_sts_t sts
);
    import hat_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PREP     = 8'b0000_0010,
        S_MULT     = 8'b0000_0100,
        S_MEAN     = 8'b0000_1000,
        S_MEAN_FIN = 8'b0001_0000,
        S_AVL_GO   = 8'b0010_0000,
        S_AVL      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = sts.was_up ? S_MEAN : S_MULT;
            end
            S_MULT:
            begin
                state_next = S_AVL_GO;
            end
            S_MEAN:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_MEAN_FIN;
                end
            end
            S_MEAN_FIN:
            begin
                cmd.mean_fin = 1'b1;
                state_next   = S_AVL_GO;
            end
            S_AVL_GO:
            begin
                cmd.avl_start = 1'b1;
                state_next    = S_AVL;
            end
            S_AVL:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/host_availability_tracker_core.sv
// Top level of the host availability tracker: controller plus datapath.
// Depends on hat_pkg, hat_ctrl, hat_dp (and hat_div through hat_dp).
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   poll in   in_valid / in_ready    poll_up method community_set ping_rtt snmp_time
//   result    out_valid / out_ready  host_state ... average_time
//   config    cfg_we                 cfg_index cfg_data
//
// An up poll runs the mean division, then the availability division; a down poll
// runs only the availability one. The shared restoring divider gives one quotient
// bit per cycle, 24 for the mean and 14 for availability. One request is in work
// at a time. The result sits in an output register, so the next request is
// accepted as soon as the result is loaded, even while out_ready is low.
// Reset is asynchronous, active low; no clearing pass is needed after reset.
`default_nettype none

module host_availability_tracker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hat_pkg::THR_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          poll_up,
    input  logic [1:0]                    method,
    input  logic                          community_set,
    input  logic [hat_pkg::TIME_W-1:0]    ping_rtt,
    input  logic [hat_pkg::TIME_W-1:0]    snmp_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    host_state,
    output logic [hat_pkg::EVT_W-1:0]     event_count,
    output logic                          state_event,
    output logic                          mark_fail_date,
    output logic                          mark_recover_date,
    output logic [hat_pkg::PCNT_W-1:0]    total_count,
    output logic [hat_pkg::PCNT_W-1:0]    failed_count,
    output logic [hat_pkg::AVL_W-1:0]     availability,
    output logic [hat_pkg::TIME_W-1:0]    current_time,
    output logic [hat_pkg::TIME_W-1:0]    minimum_time,
    output logic [hat_pkg::TIME_W-1:0]    maximum_time,
    output logic [hat_pkg::TIME_W-1:0]    average_time
);
    import hat_pkg::*;

    hat_cmd_t cmd;
    hat_sts_t sts;

    hat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    hat_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .poll_up           (poll_up),
        .method            (method),
        .community_set     (community_set),
        .ping_rtt          (ping_rtt),
        .snmp_time         (snmp_time),
        .host_state        (host_state),
        .event_count       (event_count),
        .state_event       (state_event),
        .mark_fail_date    (mark_fail_date),
        .mark_recover_date (mark_recover_date),
        .total_count       (total_count),
        .failed_count      (failed_count),
        .availability      (availability),
        .current_time      (current_time),
        .minimum_time      (minimum_time),
        .maximum_time      (maximum_time),
        .average_time      (average_time)
    );

endmodule

`default_nettype wire

FILE: src/hat_chk.sv
// Port-level checker for the host availability tracker, bound to the top level.
// Depends on hat_pkg and host_availability_tracker_core_defines.svh.
`default_nettype none
`include "host_availability_tracker_core_defines.svh"

module hat_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [1:0]                    host_state,
    input  logic [hat_pkg::EVT_W-1:0]     event_count,
    input  logic                          state_event,
    input  logic [hat_pkg::PCNT_W-1:0]    total_count,
    input  logic [hat_pkg::PCNT_W-1:0]    failed_count,
    input  logic [hat_pkg::AVL_W-1:0]     availability,
    input  logic [hat_pkg::TIME_W-1:0]    average_time
);
    import hat_pkg::*;

    logic                     accepted;
    logic                     out_stall;
    logic                     event_ok;
    logic [PCNT_W+TIME_W-1:0] res_key;

    assign accepted  = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign event_ok  = (host_state == HS_DOWN)
                       || ((host_state == HS_UP) && (event_count == '0));
    assign res_key   = {total_count, average_time};

    // one request in work at a time
    `HAT_ASSERT_NEXT(a_one_in_work, accepted, !in_ready, "request accepted while busy")

    // failed polls never exceed total polls
    `HAT_ASSERT_NOW(a_fail_le_total, out_valid, failed_count <= total_count, "failed above total")

    // availability stays within 100.00 percent
    `HAT_ASSERT_NOW(a_avail_range, out_valid, availability <= AVL_SCALE, "availability too large")

    // a declared event lands in down, or in up with a cleared counter
    `HAT_ASSERT_NOW(a_event_state, out_valid && state_event, event_ok, "bad state after event")

    // a stalled result holds
    `HAT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_key), "stalled result changed")

endmodule

bind host_availability_tracker_core hat_chk u_hat_chk (.*);

`default_nettype wire
